// ===== sv/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfd_pkg
// shared types, status codes and the byte-wide crc-16/xmodem update for the
// sensor frame deframer
// ---------------------------------------------------------------------------
package sfd_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TAG     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DATA_LEN = 2'd3;

   localparam logic [7:0] SYNC_FIRST_RST   = 8'h5A;
   localparam logic [7:0] SYNC_SECOND_RST  = 8'hA5;
   localparam logic [7:0] DATA_TAG_RST     = 8'h91;
   localparam logic [9:0] MIN_DATA_LEN_RST = 10'd76;

   localparam logic [2:0] ST_GOOD_DATA  = 3'd0;
   localparam logic [2:0] ST_GOOD_OTHER = 3'd1;
   localparam logic [2:0] ST_CRC_ERR    = 3'd2;
   localparam logic [2:0] ST_OVERSIZE   = 3'd3;
   localparam logic [2:0] ST_TRUNC      = 3'd4;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_payload;
      logic [8:0] payload_index;
      logic       frame_end;
      logic [2:0] frame_status;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/sensor_frame_deframer_crc16_unit.sv =====
// ---------------------------------------------------------------------------
// sensor_frame_deframer_crc16_unit
// byte-serial deframer with crc-16/xmodem check for a uart sensor link
// ---------------------------------------------------------------------------
// usage
//   req channel: one received byte per word (req_rx_byte) with req_burst_end
//   marking the last byte of a receive burst. a word is taken when req_valid
//   is high and req_stall is low.
//   rsp channel: zero or one word per input byte. payload bytes come out with
//   rsp_is_payload set and their index; the last word of a frame has
//   rsp_frame_end set and carries rsp_frame_status.
//   csr channel: always ready; index 0 sync_first, 1 sync_second,
//   2 data_tag, 3 min_data_len. write only while the block is idle.
//   output: a result is registered in the output register, or in the skid entry while rsp is stalled.
//   throughput: one byte per cycle while req_stall is low; the header parse and the unrolled
//   byte-wide crc update finish in the accept cycle.
//   stall: the output register plus a one-entry skid absorbs one result
//   while rsp is stalled; req_stall rises only while both are full.
//   reset: synchronous, returns registers to defaults and hunting for sync.
// ---------------------------------------------------------------------------
module sensor_frame_deframer_crc16_unit #(
   parameter int unsigned MAX_PAYLOAD = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             req_burst_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_is_payload,
   output logic [8:0]                       rsp_payload_index,
   output logic                             rsp_frame_end,
   output logic [2:0]                       rsp_frame_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] PH_HUNT1  = 3'd0;
   localparam logic [2:0] PH_HUNT2  = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_CHK_LO = 3'd4;
   localparam logic [2:0] PH_CHK_HI = 3'd5;
   localparam logic [2:0] PH_DATA   = 3'd6;

   logic [7:0]  sync_first_ff, sync_second_ff, data_tag_ff;
   logic [9:0]  min_len_ff;

   logic [2:0]       phase_ff, phase_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      chk_ff, chk_in;
   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             tag_ff, tag_in;

   sfd_pkg::result_type res;
   logic                emit;
   logic [15:0]         pos_ext, pos_next, len_full;
   logic                tag_now;

   sfd_pkg::result_type out_ff, skid_ff;
   logic                out_valid_ff, skid_valid_ff;
   logic                accept, out_take;

   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= sfd_pkg::SYNC_FIRST_RST;
         sync_second_ff <= sfd_pkg::SYNC_SECOND_RST;
         data_tag_ff    <= sfd_pkg::DATA_TAG_RST;
         min_len_ff     <= sfd_pkg::MIN_DATA_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sfd_pkg::CSR_SYNC_FIRST:   sync_first_ff  <= csr_data[7:0];
            sfd_pkg::CSR_SYNC_SECOND:  sync_second_ff <= csr_data[7:0];
            sfd_pkg::CSR_DATA_TAG:     data_tag_ff    <= csr_data[7:0];
            sfd_pkg::CSR_MIN_DATA_LEN: min_len_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [2:0] status_of(input logic [15:0] crc, input logic [15:0] chk,
                                            input logic tag, input logic [15:0] len,
                                            input logic [9:0] min_len);
      logic [2:0] s;
      if (crc != chk) begin
         s = sfd_pkg::ST_CRC_ERR;
      end else if (tag && (len >= {6'd0, min_len})) begin
         s = sfd_pkg::ST_GOOD_DATA;
      end else begin
         s = sfd_pkg::ST_GOOD_OTHER;
      end
      return s;
   endfunction

   assign pos_ext  = 16'(pos_ff);
   assign pos_next = pos_ext + 16'd1;
   assign len_full = {req_rx_byte, len_ff[7:0]};
   assign tag_now  = (pos_ff == '0) ? (req_rx_byte == data_tag_ff) : tag_ff;

   // parse one byte
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      chk_in   = chk_ff;
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      tag_in   = tag_ff;
      emit     = 1'b0;
      res      = '0;
      unique case (phase_ff)
         PH_HUNT1: begin
            if (req_rx_byte == sync_first_ff) begin
               phase_in = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            if (req_rx_byte == sync_second_ff) begin
               crc_in   = sfd_pkg::crc_byte(sfd_pkg::crc_byte(16'h0000, sync_first_ff),
                                            req_rx_byte);
               len_in   = '0;
               chk_in   = '0;
               pos_in   = '0;
               tag_in   = 1'b0;
               phase_in = PH_LEN_LO;
            end else if (req_rx_byte != sync_first_ff) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_LEN_LO: begin
            len_in   = {8'h00, req_rx_byte};
            crc_in   = sfd_pkg::crc_byte(crc_ff, req_rx_byte);
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in = len_full;
            crc_in = sfd_pkg::crc_byte(crc_ff, req_rx_byte);
            if (len_full > 16'(MAX_PAYLOAD)) begin
               emit             = 1'b1;
               res.frame_end    = 1'b1;
               res.frame_status = sfd_pkg::ST_OVERSIZE;
               phase_in         = PH_HUNT1;
            end else begin
               phase_in = PH_CHK_LO;
            end
         end
         PH_CHK_LO: begin
            chk_in   = {8'h00, req_rx_byte};
            phase_in = PH_CHK_HI;
         end
         PH_CHK_HI: begin
            chk_in = {req_rx_byte, chk_ff[7:0]};
            if (len_ff == '0) begin
               emit             = 1'b1;
               res.frame_end    = 1'b1;
               res.frame_status = status_of(crc_ff, {req_rx_byte, chk_ff[7:0]}, tag_ff,
                                            len_ff, min_len_ff);
               phase_in         = PH_HUNT1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            tag_in            = tag_now;
            crc_in            = sfd_pkg::crc_byte(crc_ff, req_rx_byte);
            emit              = 1'b1;
            res.payload_byte  = req_rx_byte;
            res.is_payload    = 1'b1;
            res.payload_index = pos_ext[8:0];
            pos_in            = POS_W'(pos_next);
            if (pos_next >= len_ff) begin
               res.frame_end    = 1'b1;
               res.frame_status = status_of(crc_in, chk_ff, tag_now, len_ff, min_len_ff);
               phase_in         = PH_HUNT1;
            end
         end
         default: begin
            phase_in = PH_HUNT1;
         end
      endcase
      if (req_burst_end && (phase_in != PH_HUNT1)) begin
         if (phase_in != PH_HUNT2) begin
            emit             = 1'b1;
            res.frame_end    = 1'b1;
            res.frame_status = sfd_pkg::ST_TRUNC;
         end
         phase_in = PH_HUNT1;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         len_ff   <= '0;
         chk_ff   <= '0;
         crc_ff   <= '0;
         pos_ff   <= '0;
         tag_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         chk_ff   <= chk_in;
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         tag_ff   <= tag_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end
      if (!skid_valid_ff) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_is_payload    = out_ff.is_payload;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_frame_status  = out_ff.frame_status;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   a_result_has_purpose: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_payload || rsp_frame_end))
      else $error("result word carries neither payload nor frame end");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |-> (rsp_frame_status == sfd_pkg::ST_GOOD_DATA))
      else $error("status set on a word that does not end a frame");

   a_burst_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_burst_end) |=> (phase_ff == PH_HUNT1))
      else $error("parser not hunting after burst end");

   a_no_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_payload) |-> (rsp_payload_byte == 8'h00 &&
                                          rsp_payload_index == 9'd0))
      else $error("payload fields set on a status-only word");

endmodule
